// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold after the delay given by dly, counted from the antecedent.
`define QVR_ASSERT_DELAY(lbl, ck, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/qvr_pkg.sv
// Types and constants for the quaternion vector rotation pipeline.
package qvr_pkg;

	localparam int COORD_W    = 16;
	localparam int QUAT_W     = 16;
	localparam int QUAT_FRAC  = 14;
	localparam int OUT_SHIFT  = 2 * QUAT_FRAC;
	localparam int PROD1_W    = COORD_W + QUAT_W;
	localparam int P_W        = PROD1_W + 2;
	localparam int PROD2_W    = P_W + QUAT_W;
	localparam int ACC_W      = PROD2_W + 2;
	localparam int PIPE_LAT   = 5;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << QUAT_FRAC);

	typedef enum logic [1:0] {
		REG_QUAT_W = 2'd0,
		REG_QUAT_X = 2'd1,
		REG_QUAT_Y = 2'd2,
		REG_QUAT_Z = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vec_x;
		logic signed [COORD_W-1:0] vec_y;
		logic signed [COORD_W-1:0] vec_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rot_x;
		logic signed [COORD_W-1:0] rot_y;
		logic signed [COORD_W-1:0] rot_z;
		logic                      clipped;
	} rot_out_t;

	// q * (0, v), full precision
	typedef struct packed {
		logic signed [P_W-1:0] pw;
		logic signed [P_W-1:0] px;
		logic signed [P_W-1:0] py;
		logic signed [P_W-1:0] pz;
	} pquat_t;

	// Unshifted vector part of p * conj(q)
	typedef struct packed {
		logic signed [ACC_W-1:0] ax;
		logic signed [ACC_W-1:0] ay;
		logic signed [ACC_W-1:0] az;
	} acc_vec_t;

endpackage

// File: rtl/qvr_regs.sv
// Quaternion configuration registers.
module qvr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [qvr_pkg::QUAT_W-1:0]  cfg_wdata,
	output qvr_pkg::quat_t              quat
);
	import qvr_pkg::*;

	quat_t quat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= QUAT_ONE;
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				REG_QUAT_W: quat_q.w <= cfg_wdata;
				REG_QUAT_X: quat_q.x <= cfg_wdata;
				REG_QUAT_Y: quat_q.y <= cfg_wdata;
				REG_QUAT_Z: quat_q.z <= cfg_wdata;
				default: quat_q <= quat_q;
			endcase
		end
	end

	assign quat = quat_q;
endmodule

// File: rtl/qvr_ham1.sv
// First Hamilton product q * (0, v): multiply stage, then sum stage.
module qvr_ham1 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  qvr_pkg::vec_in_t vec,
	input  qvr_pkg::quat_t   quat,
	output logic             out_vld,
	output qvr_pkg::pquat_t  p
);
	import qvr_pkg::*;

	logic signed [PROD1_W-1:0] m_s1 [12];
	logic                      vld_s1;
	logic                      vld_s2;
	pquat_t                    p_s2;
	logic signed [P_W-1:0]     e [12];

	always_ff @(posedge clk) begin
		m_s1[0]  <= PROD1_W'(quat.x) * PROD1_W'(vec.vec_x);
		m_s1[1]  <= PROD1_W'(quat.y) * PROD1_W'(vec.vec_y);
		m_s1[2]  <= PROD1_W'(quat.z) * PROD1_W'(vec.vec_z);
		m_s1[3]  <= PROD1_W'(quat.w) * PROD1_W'(vec.vec_x);
		m_s1[4]  <= PROD1_W'(quat.y) * PROD1_W'(vec.vec_z);
		m_s1[5]  <= PROD1_W'(quat.z) * PROD1_W'(vec.vec_y);
		m_s1[6]  <= PROD1_W'(quat.w) * PROD1_W'(vec.vec_y);
		m_s1[7]  <= PROD1_W'(quat.x) * PROD1_W'(vec.vec_z);
		m_s1[8]  <= PROD1_W'(quat.z) * PROD1_W'(vec.vec_x);
		m_s1[9]  <= PROD1_W'(quat.w) * PROD1_W'(vec.vec_z);
		m_s1[10] <= PROD1_W'(quat.x) * PROD1_W'(vec.vec_y);
		m_s1[11] <= PROD1_W'(quat.y) * PROD1_W'(vec.vec_x);
	end

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			e[i] = P_W'(m_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		p_s2.pw <= -e[0] - e[1] - e[2];
		p_s2.px <= e[3] + e[4] - e[5];
		p_s2.py <= e[6] - e[7] + e[8];
		p_s2.pz <= e[9] + e[10] - e[11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign p       = p_s2;
endmodule

// File: rtl/qvr_ham2.sv
// Second Hamilton product p * conj(q), vector part: multiply stage, then sum stage.
module qvr_ham2 (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  qvr_pkg::pquat_t   p,
	input  qvr_pkg::quat_t    quat,
	output logic              out_vld,
	output qvr_pkg::acc_vec_t acc
);
	import qvr_pkg::*;

	logic signed [PROD2_W-1:0] m_s3 [12];
	logic                      vld_s3;
	logic                      vld_s4;
	acc_vec_t                  acc_s4;
	logic signed [ACC_W-1:0]   e [12];

	always_ff @(posedge clk) begin
		m_s3[0]  <= PROD2_W'(p.pw) * PROD2_W'(quat.x);
		m_s3[1]  <= PROD2_W'(p.px) * PROD2_W'(quat.w);
		m_s3[2]  <= PROD2_W'(p.py) * PROD2_W'(quat.z);
		m_s3[3]  <= PROD2_W'(p.pz) * PROD2_W'(quat.y);
		m_s3[4]  <= PROD2_W'(p.pw) * PROD2_W'(quat.y);
		m_s3[5]  <= PROD2_W'(p.px) * PROD2_W'(quat.z);
		m_s3[6]  <= PROD2_W'(p.py) * PROD2_W'(quat.w);
		m_s3[7]  <= PROD2_W'(p.pz) * PROD2_W'(quat.x);
		m_s3[8]  <= PROD2_W'(p.pw) * PROD2_W'(quat.z);
		m_s3[9]  <= PROD2_W'(p.px) * PROD2_W'(quat.y);
		m_s3[10] <= PROD2_W'(p.py) * PROD2_W'(quat.x);
		m_s3[11] <= PROD2_W'(p.pz) * PROD2_W'(quat.w);
	end

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			e[i] = ACC_W'(m_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		acc_s4.ax <= -e[0] + e[1] - e[2] + e[3];
		acc_s4.ay <= -e[4] + e[5] + e[6] - e[7];
		acc_s4.az <= -e[8] - e[9] + e[10] + e[11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
		end
	end

	assign out_vld = vld_s4;
	assign acc     = acc_s4;
endmodule

// File: rtl/qvr_sat.sv
// Output stage: drop the fraction bits, saturate, flag clipping.
module qvr_sat (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  qvr_pkg::acc_vec_t acc,
	output logic              out_vld,
	output qvr_pkg::rot_out_t rot
);
	import qvr_pkg::*;

	localparam int TOP = OUT_SHIFT + COORD_W - 1;

	logic                      vld_s5;
	rot_out_t                  rot_s5;
	logic signed [COORD_W-1:0] sx, sy, sz;
	logic                      cx, cy, cz;

	function automatic logic ovf(input logic signed [ACC_W-1:0] a);
		// out of range unless all bits above the result agree with its sign
		ovf = !((&a[ACC_W-1:TOP]) || !(|a[ACC_W-1:TOP]));
	endfunction

	function automatic logic signed [COORD_W-1:0] clampv(input logic signed [ACC_W-1:0] a);
		if (ovf(a)) begin
			clampv = a[ACC_W-1] ? COORD_MIN : COORD_MAX;
		end else begin
			clampv = a[TOP:OUT_SHIFT];
		end
	endfunction

	always_comb begin
		sx = clampv(acc.ax);
		sy = clampv(acc.ay);
		sz = clampv(acc.az);
		cx = ovf(acc.ax);
		cy = ovf(acc.ay);
		cz = ovf(acc.az);
	end

	always_ff @(posedge clk) begin
		rot_s5.rot_x   <= sx;
		rot_s5.rot_y   <= sy;
		rot_s5.rot_z   <= sz;
		rot_s5.clipped <= cx | cy | cz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= in_vld;
		end
	end

	assign out_vld = vld_s5;
	assign rot     = rot_s5;
endmodule

// File: rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation pipeline.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------
//  request   | start / busy     | vec (vec_x, vec_y, vec_z)
//  result    | done (strobe)    | rot (rot_x, rot_y, rot_z, clipped)
//  config    | cfg_we           | cfg_idx, cfg_wdata
//
// One request per cycle; each result passes through five register stages after its
// request is taken: two multiply banks, two adder stages, saturation. busy stays low:
// the pipeline never stalls; the receiver must take every result, unenforced by the block.
// Reset clears the valid bits and loads the identity quaternion.
module quaternion_vector_rotate (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  qvr_pkg::vec_in_t           vec,
	output logic                       done,
	output qvr_pkg::rot_out_t          rot,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [qvr_pkg::QUAT_W-1:0] cfg_wdata
);
	import qvr_pkg::*;

	quat_t    quat;
	logic     p_vld;
	pquat_t   p;
	logic     acc_vld;
	acc_vec_t acc;
	logic     accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	qvr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.quat      (quat)
	);

	qvr_ham1 u_ham1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.vec     (vec),
		.quat    (quat),
		.out_vld (p_vld),
		.p       (p)
	);

	qvr_ham2 u_ham2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (p_vld),
		.p       (p),
		.quat    (quat),
		.out_vld (acc_vld),
		.acc     (acc)
	);

	qvr_sat u_sat (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc_vld),
		.acc     (acc),
		.out_vld (done),
		.rot     (rot)
	);
endmodule

// File: rtl/qvr_checker.sv
// Port-level checker for the rotation block, bound to the top level.
`include "assert_macros.svh"

module qvr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input qvr_pkg::rot_out_t          rot
);
	import qvr_pkg::*;

	logic req;
	logic at_bound;

	assign req = start && !busy;
	assign at_bound = (rot.rot_x == COORD_MAX) || (rot.rot_x == COORD_MIN) ||
		(rot.rot_y == COORD_MAX) || (rot.rot_y == COORD_MIN) ||
		(rot.rot_z == COORD_MAX) || (rot.rot_z == COORD_MIN);

	`QVR_ASSERT_DELAY(a_req_gives_done, clk, arst_n, req, PIPE_LAT, done)
	`QVR_ASSERT_DELAY(a_no_req_no_done, clk, arst_n, !req, PIPE_LAT, !done)
	`QVR_ASSERT_IMPL(a_clip_at_bound, clk, arst_n, done && rot.clipped, at_bound)
endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

// File: bench/tb.sv
// Self-checking bench for the quaternion vector rotation pipeline.
module tb;
	import qvr_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	typedef enum logic [1:0] {
		OP_REQ,
		OP_CFG,
		OP_PAUSE
	} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		int               idle_pct;
		vec_in_t          vec;
		cfg_idx_t         idx;
		logic [QUAT_W-1:0] data;
	} op_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	vec_in_t           vec = '0;
	logic              done;
	rot_out_t          rot;
	logic              cfg_we = 1'b0;
	cfg_idx_t          cfg_idx = REG_QUAT_W;
	logic [QUAT_W-1:0] cfg_wdata = '0;

	op_t      pending[$];
	rot_out_t rot_expect[$];
	quat_t    model_q;
	logic     taken = 1'b0;
	int       err_cnt = 0;
	int       cycle_cnt = 0;

	quaternion_vector_rotate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.vec       (vec),
		.done      (done),
		.rot       (rot),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// v' = vector part of q * (0,v) * conj(q), floor-shifted and saturated
	function automatic rot_out_t rotate_vec(quat_t q, vec_in_t v);
		longint w, x, y, z, vx, vy, vz, pw, px, py, pz, s;
		longint acc [3];
		logic signed [COORD_W-1:0] c [3];
		rot_out_t r;
		w = longint'(q.w);
		x = longint'(q.x);
		y = longint'(q.y);
		z = longint'(q.z);
		vx = longint'(v.vec_x);
		vy = longint'(v.vec_y);
		vz = longint'(v.vec_z);
		pw = -(x * vx) - (y * vy) - (z * vz);
		px = w * vx + y * vz - z * vy;
		py = w * vy - x * vz + z * vx;
		pz = w * vz + x * vy - y * vx;
		acc[0] = -(pw * x) + px * w - py * z + pz * y;
		acc[1] = -(pw * y) + px * z + py * w - pz * x;
		acc[2] = -(pw * z) - px * y + py * x + pz * w;
		r.clipped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			s = acc[i] >>> OUT_SHIFT;
			if (s > longint'(COORD_MAX)) begin
				c[i] = COORD_MAX;
				r.clipped = 1'b1;
			end else if (s < longint'(COORD_MIN)) begin
				c[i] = COORD_MIN;
				r.clipped = 1'b1;
			end else begin
				c[i] = s[COORD_W-1:0];
			end
		end
		r.rot_x = c[0];
		r.rot_y = c[1];
		r.rot_z = c[2];
		return r;
	endfunction

	task automatic note_fail(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0d: %s", cycle_cnt, msg);
	endtask

	// Driver: at most one request or register write per falling edge.
	always @(negedge clk) begin
		op_t  op;
		logic drive_req;
		logic drive_cfg;
		drive_req = 1'b0;
		drive_cfg = 1'b0;
		if (arst_n) begin
			if (start && taken)
				void'(pending.pop_front());
			if (pending.size() != 0) begin
				op = pending[0];
				case (op.kind)
					OP_REQ: drive_req = (start && !taken) || ($urandom_range(99) >= op.idle_pct);
					OP_CFG: if (rot_expect.size() == 0) begin
						drive_cfg = 1'b1;
						void'(pending.pop_front());
					end
					OP_PAUSE: if (rot_expect.size() == 0)
						void'(pending.pop_front());
					default: ;
				endcase
			end
		end
		start <= drive_req;
		if (drive_req)
			vec <= op.vec;
		cfg_we <= drive_cfg;
		if (drive_cfg) begin
			cfg_idx   <= op.idx;
			cfg_wdata <= op.data;
		end
	end

	// Monitor: predict on each accepted request, check each result strobe.
	always @(posedge clk) begin
		rot_out_t exp_rot;
		if (!arst_n) begin
			taken   <= 1'b0;
			model_q = '{w: QUAT_ONE, x: '0, y: '0, z: '0};
		end else begin
			taken <= start && !busy;
			if (cfg_we) begin
				case (cfg_idx)
					REG_QUAT_W: model_q.w = cfg_wdata;
					REG_QUAT_X: model_q.x = cfg_wdata;
					REG_QUAT_Y: model_q.y = cfg_wdata;
					REG_QUAT_Z: model_q.z = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				rot_expect.push_back(rotate_vec(model_q, vec));
			if (done) begin
				if (rot_expect.size() == 0) begin
					note_fail($sformatf("result with no request pending: %p", rot));
				end else begin
					exp_rot = rot_expect.pop_front();
					if (rot.rot_x !== exp_rot.rot_x || rot.rot_y !== exp_rot.rot_y ||
					    rot.rot_z !== exp_rot.rot_z || rot.clipped !== exp_rot.clipped)
						note_fail($sformatf("rot mismatch: expected %p got %p", exp_rot, rot));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic add_request(int x, int y, int z, int idle_pct);
		op_t op;
		op.kind = OP_REQ;
		op.idle_pct = idle_pct;
		op.vec.vec_x = x[COORD_W-1:0];
		op.vec.vec_y = y[COORD_W-1:0];
		op.vec.vec_z = z[COORD_W-1:0];
		op.idx = REG_QUAT_W;
		op.data = '0;
		pending.push_back(op);
	endtask

	task automatic add_pause();
		op_t op;
		op.kind = OP_PAUSE;
		op.idle_pct = 0;
		op.vec = '0;
		op.idx = REG_QUAT_W;
		op.data = '0;
		pending.push_back(op);
	endtask

	task automatic add_quat(int w, int x, int y, int z);
		op_t op;
		op.kind = OP_CFG;
		op.idle_pct = 0;
		op.vec = '0;
		op.idx = REG_QUAT_W;
		op.data = w[QUAT_W-1:0];
		pending.push_back(op);
		op.idx = REG_QUAT_X;
		op.data = x[QUAT_W-1:0];
		pending.push_back(op);
		op.idx = REG_QUAT_Y;
		op.data = y[QUAT_W-1:0];
		pending.push_back(op);
		op.idx = REG_QUAT_Z;
		op.data = z[QUAT_W-1:0];
		pending.push_back(op);
	endtask

	function automatic int rand_coord();
		if ($urandom_range(3) == 0)
			return $urandom_range(600) - 300;
		return $urandom();
	endfunction

	function automatic int rand_quat_part(int kind);
		int corner;
		case (kind)
			0: return $urandom();
			1: return $urandom_range(16384) - 8192;
			2: begin
				corner = $urandom_range(3);
				return (corner == 0) ? 32767 : (corner == 1) ? -32768 :
					(corner == 2) ? 0 : int'(QUAT_ONE);
			end
			default: return $urandom_range(23170) - 11585;
		endcase
	endfunction

	initial begin
		int idle_plan [8];
		idle_plan = '{0, 87, 30, 0, 87, 30, 0, 87};

		// identity from reset
		add_request(0, 0, 0, 0);
		add_request(32767, 32767, 32767, 0);
		add_request(-32768, -32768, -32768, 0);
		add_request(32767, -32768, 1, 0);
		add_request(-1, -1, -1, 0);
		add_request(1, 0, -1, 0);
		// 90 degrees about z, not exactly unit: exercises truncation
		add_quat(11585, 0, 0, 11585);
		add_request(32767, 0, 0, 0);
		add_request(-32768, 32767, -32768, 0);
		add_request(1, 1, 1, 0);
		// largest negative quaternion scales by 16: saturate both ways
		add_quat(-32768, -32768, -32768, -32768);
		add_request(1, -1, 1, 0);
		add_request(32767, 32767, 32767, 0);
		add_request(-32768, -32768, -32768, 0);
		add_request(-2048, 2047, -2048, 0);
		add_quat(32767, 32767, 32767, 32767);
		add_request(-32768, 32767, 0, 0);
		add_request(100, -100, 7, 0);
		// zero quaternion
		add_quat(0, 0, 0, 0);
		add_request(32767, -32768, 12345, 0);
		// half turn about x
		add_quat(0, 16384, 0, 0);
		add_request(100, -200, 300, 0);
		add_pause();

		for (int ph = 0; ph < 8; ph++) begin
			add_quat(rand_quat_part(ph % 4), rand_quat_part(ph % 4),
				rand_quat_part(ph % 4), rand_quat_part(ph % 4));
			for (int i = 0; i < 180; i++) begin
				if (i == 90)
					add_pause();
				add_request(rand_coord(), rand_coord(), rand_coord(), idle_plan[ph]);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || rot_expect.size() != 0 || start)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);

		if (err_cnt == 0 && rot_expect.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_regs.sv
rtl/qvr_ham1.sv
rtl/qvr_ham2.sv
rtl/qvr_sat.sv
rtl/quaternion_vector_rotate.sv
rtl/qvr_checker.sv
bench/tb.sv
